// ===== rtl/afp_pkg.sv =====
package afp_pkg;

	localparam int MAX_FINGERS = 5;
	localparam int ANGLE_COUNT = 2 * MAX_FINGERS;
	localparam int IDX_W       = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0]  HEADER_LO      = 8'h55;
	localparam logic [7:0]  HEADER_HI      = 8'hAA;
	localparam logic [7:0]  FRAME_VERSION  = 8'h01;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'h1021;
	localparam logic [15:0] ROLL_LIMIT_Q8  = 16'd46080;
	localparam logic [15:0] PITCH_LIMIT_Q8 = 16'd23040;

	typedef struct packed {
		logic [31:0]                        timestamp;
		logic [ANGLE_COUNT-1:0][15:0]       angle;
	} afp_frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} afp_qstat_t;

	// Clamp a Q15.8 angle and convert to int16 centidegrees, toward zero; an invalid angle gives zero.
	function automatic logic [15:0] to_centideg(logic signed [23:0] v, logic [15:0] limit,
			logic invalid);
		logic signed [24:0] vx;
		logic signed [24:0] lim;
		logic signed [24:0] vneg;
		logic [15:0]        mag;
		logic [22:0]        prod;
		logic [15:0]        cd;
		vx   = {v[23], v};
		lim  = {9'd0, limit};
		vneg = -vx;
		if (vx > lim || vx < -lim) begin
			mag = limit;
		end else if (v[23]) begin
			mag = vneg[15:0];
		end else begin
			mag = vx[15:0];
		end
		prod = ({7'd0, mag} << 6) + ({7'd0, mag} << 5) + ({7'd0, mag} << 2);
		cd   = {1'b0, prod[22:8]};
		if (invalid) begin
			return 16'd0;
		end
		return v[23] ? (16'd0 - cd) : cd;
	endfunction

	function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/afp_front.sv =====
module afp_front import afp_pkg::*; #(
	parameter int FINGER_COUNT = 5
) (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       timestamp_ms,
	input  logic signed [23:0] roll_0,
	input  logic signed [23:0] pitch_0,
	input  logic signed [23:0] roll_1,
	input  logic signed [23:0] pitch_1,
	input  logic signed [23:0] roll_2,
	input  logic signed [23:0] pitch_2,
	input  logic signed [23:0] roll_3,
	input  logic signed [23:0] pitch_3,
	input  logic signed [23:0] roll_4,
	input  logic signed [23:0] pitch_4,
	input  logic [9:0]        invalid_mask,
	input  afp_qstat_t        qstat,
	output logic              push,
	output afp_frame_t        push_data
);

	logic signed [23:0] raw [ANGLE_COUNT];

	assign raw[0] = roll_0;
	assign raw[1] = pitch_0;
	assign raw[2] = roll_1;
	assign raw[3] = pitch_1;
	assign raw[4] = roll_2;
	assign raw[5] = pitch_2;
	assign raw[6] = roll_3;
	assign raw[7] = pitch_3;
	assign raw[8] = roll_4;
	assign raw[9] = pitch_4;

	assign in_ready = !qstat.full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_data.timestamp = timestamp_ms;
		for (int k = 0; k < ANGLE_COUNT; k++) begin
			// drop angles of fingers that are not fitted
			if (k < 2 * FINGER_COUNT) begin
				push_data.angle[k] = to_centideg(raw[k],
					(k % 2 == 0) ? ROLL_LIMIT_Q8 : PITCH_LIMIT_Q8, invalid_mask[k]);
			end else begin
				push_data.angle[k] = 16'd0;
			end
		end
	end

endmodule

// ===== rtl/afp_queue.sv =====
module afp_queue import afp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  afp_frame_t push_data,
	input  logic       pop,
	output afp_frame_t head,
	output afp_qstat_t qstat
);

	afp_frame_t          mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/afp_back.sv =====
module afp_back import afp_pkg::*; #(
	parameter int FINGER_COUNT = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  afp_frame_t head,
	input  afp_qstat_t qstat,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] frame_byte,
	output logic       last_byte
);

	localparam int BODY_LEN  = 7 + 4 * FINGER_COUNT;
	localparam int FRAME_LEN = BODY_LEN + 2;

	logic [IDX_W-1:0] idx_q;
	logic [15:0]      crc_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic [IDX_W-1:0] ts_off;
	logic [IDX_W-1:0] ang_off;
	logic [7:0]       cur_byte;
	logic [15:0]      crc_next;
	logic             is_last;
	logic             emit;

	assign ts_off  = idx_q - IDX_W'(3);
	assign ang_off = idx_q - IDX_W'(7);
	assign is_last = (idx_q == IDX_W'(FRAME_LEN - 1));
	assign emit    = !qstat.empty && (!out_valid_q || out_ready);
	assign pop     = emit && is_last;

	always_comb begin
		if (idx_q == IDX_W'(0)) begin
			cur_byte = HEADER_LO;
		end else if (idx_q == IDX_W'(1)) begin
			cur_byte = HEADER_HI;
		end else if (idx_q == IDX_W'(2)) begin
			cur_byte = FRAME_VERSION;
		end else if (idx_q < IDX_W'(7)) begin
			cur_byte = head.timestamp[ts_off[1:0]*8 +: 8];
		end else if (idx_q < IDX_W'(BODY_LEN)) begin
			cur_byte = head.angle[ang_off[4:1]][ang_off[0]*8 +: 8];
		end else if (idx_q == IDX_W'(BODY_LEN)) begin
			cur_byte = crc_q[7:0];
		end else begin
			cur_byte = crc_q[15:8];
		end
		// header bytes stay out of the checksum
		if (idx_q >= IDX_W'(2) && idx_q < IDX_W'(BODY_LEN)) begin
			crc_next = crc_byte(crc_q, cur_byte);
		end else begin
			crc_next = crc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
			idx_q       <= is_last ? '0 : idx_q + 1'b1;
			crc_q       <= is_last ? CRC_INIT : crc_next;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= cur_byte;
			out_last_q <= is_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = out_byte_q;
	assign last_byte  = out_last_q;

`ifndef NO_ASSERTIONS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < IDX_W'(FRAME_LEN))
		else $error("byte index past end of frame");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (idx_q == '0) && (crc_q == CRC_INIT))
		else $error("frame state not restarted after last byte");
`endif

endmodule

// ===== rtl/angle_frame_packer_crc16_core.sv =====
// An accepted item is written into the queue, and its first frame byte then leaves
// through the output register. Each item makes 7 + 4*FINGER_COUNT + 2 bytes (29 at
// five fingers), sent one byte per cycle on the output channel while out_ready holds.
// A two-item queue lets the input side accept while the serializer is busy.
// Reset (arst_n low, asynchronous) empties the queue and output register and
// restarts the byte counter and CRC.
module angle_frame_packer_crc16_core import afp_pkg::*; #(
	parameter int FINGER_COUNT = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        timestamp_ms,
	input  logic signed [23:0] roll_0,
	input  logic signed [23:0] pitch_0,
	input  logic signed [23:0] roll_1,
	input  logic signed [23:0] pitch_1,
	input  logic signed [23:0] roll_2,
	input  logic signed [23:0] pitch_2,
	input  logic signed [23:0] roll_3,
	input  logic signed [23:0] pitch_3,
	input  logic signed [23:0] roll_4,
	input  logic signed [23:0] pitch_4,
	input  logic [9:0]         invalid_mask,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         frame_byte,
	output logic               last_byte
);

	afp_qstat_t qstat;
	afp_frame_t push_data;
	afp_frame_t head;
	logic       push;
	logic       pop;

	afp_front #(.FINGER_COUNT(FINGER_COUNT)) u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.timestamp_ms (timestamp_ms),
		.roll_0       (roll_0),
		.pitch_0      (pitch_0),
		.roll_1       (roll_1),
		.pitch_1      (pitch_1),
		.roll_2       (roll_2),
		.pitch_2      (pitch_2),
		.roll_3       (roll_3),
		.pitch_3      (pitch_3),
		.roll_4       (roll_4),
		.pitch_4      (pitch_4),
		.invalid_mask (invalid_mask),
		.qstat        (qstat),
		.push         (push),
		.push_data    (push_data)
	);

	afp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	afp_back #(.FINGER_COUNT(FINGER_COUNT)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

// ===== test/angle_frame_packer_crc16_core_tb.sv =====
module angle_frame_packer_crc16_core_tb;
	import afp_pkg::*;

	localparam int FINGERS     = 5;
	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_beat_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [31:0]        timestamp_ms = '0;
	logic signed [23:0] roll_0 = '0;
	logic signed [23:0] pitch_0 = '0;
	logic signed [23:0] roll_1 = '0;
	logic signed [23:0] pitch_1 = '0;
	logic signed [23:0] roll_2 = '0;
	logic signed [23:0] pitch_2 = '0;
	logic signed [23:0] roll_3 = '0;
	logic signed [23:0] pitch_3 = '0;
	logic signed [23:0] roll_4 = '0;
	logic signed [23:0] pitch_4 = '0;
	logic [9:0]         invalid_mask = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [7:0]         frame_byte;
	logic               last_byte;

	frame_beat_t pending_bytes[$];
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          sink_hold = 0;
	bit          idle_en = 1'b1;

	angle_frame_packer_crc16_core #(.FINGER_COUNT(FINGERS)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.timestamp_ms (timestamp_ms),
		.roll_0       (roll_0),
		.pitch_0      (pitch_0),
		.roll_1       (roll_1),
		.pitch_1      (pitch_1),
		.roll_2       (roll_2),
		.pitch_2      (pitch_2),
		.roll_3       (roll_3),
		.pitch_3      (pitch_3),
		.roll_4       (roll_4),
		.pitch_4      (pitch_4),
		.invalid_mask (invalid_mask),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_byte   (frame_byte),
		.last_byte    (last_byte)
	);

	always #6 clk = ~clk;

	function automatic logic [15:0] centideg(logic signed [23:0] q8, int limit, logic invalid);
		int          v;
		int          cd;
		logic [15:0] mag_cd;
		if (invalid)
			return 16'd0;
		v = q8;
		if (v > limit)
			v = limit;
		if (v < -limit)
			v = -limit;
		cd = ((v < 0) ? -v : v) * 100;
		mag_cd = cd[23:8];
		return (v < 0) ? -mag_cd : mag_cd;
	endfunction

	// Bit-serial form of the CCITT update, MSB first.
	function automatic logic [15:0] crc16_ccitt_step(logic [15:0] crc, logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = crc[15] ^ b[i];
			crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return crc;
	endfunction

	function automatic void queue_frame(logic [31:0] ts, logic [9:0][23:0] ang,
			logic [9:0] mask);
		logic [7:0]  body[$];
		logic [15:0] crc;
		logic [15:0] cd;
		frame_beat_t beat;
		body = '{HEADER_LO, HEADER_HI, FRAME_VERSION, ts[7:0], ts[15:8], ts[23:16], ts[31:24]};
		for (int k = 0; k < 2 * FINGERS; k++) begin
			cd = centideg(ang[k], (k % 2 == 0) ? int'(ROLL_LIMIT_Q8) : int'(PITCH_LIMIT_Q8),
				mask[k]);
			body.push_back(cd[7:0]);
			body.push_back(cd[15:8]);
		end
		crc = CRC_INIT;
		for (int i = 2; i < body.size(); i++)
			crc = crc16_ccitt_step(crc, body[i]);
		foreach (body[i]) begin
			beat.data = body[i];
			beat.last = 1'b0;
			pending_bytes.push_back(beat);
		end
		beat.data = crc[7:0];
		beat.last = 1'b0;
		pending_bytes.push_back(beat);
		beat.data = crc[15:8];
		beat.last = 1'b1;
		pending_bytes.push_back(beat);
	endfunction

	function automatic logic [9:0][23:0] angles_of(int roll_v, int pitch_v);
		logic [9:0][23:0] ang;
		for (int k = 0; k < 10; k++)
			ang[k] = (k % 2 == 0) ? 24'(roll_v) : 24'(pitch_v);
		return ang;
	endfunction

	function automatic logic [23:0] random_angle(bit is_roll);
		int lim;
		int sel;
		int v;
		lim = is_roll ? int'(ROLL_LIMIT_Q8) : int'(PITCH_LIMIT_Q8);
		sel = $urandom_range(0, 9);
		if (sel < 6)
			v = int'($urandom_range(0, 2 * lim + 512)) - lim - 256;
		else if (sel < 8)
			v = $urandom;
		else if (sel == 8)
			v = int'($urandom_range(0, 600)) - 300;
		else begin
			case ($urandom_range(0, 5))
				0: v = lim;
				1: v = -lim;
				2: v = lim + 1;
				3: v = -lim - 1;
				4: v = 24'h7FFFFF;
				default: v = -8388608;
			endcase
		end
		return v[23:0];
	endfunction

	function automatic logic [9:0][23:0] random_angles();
		logic [9:0][23:0] ang;
		for (int k = 0; k < 10; k++)
			ang[k] = random_angle(k % 2 == 0);
		return ang;
	endfunction

	task automatic send_sample(input logic [31:0] ts, input logic [9:0][23:0] ang,
			input logic [9:0] mask);
		int gap;
		gap = 0;
		if (idle_en && $urandom_range(0, 2) == 0)
			gap = $urandom_range(1, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		timestamp_ms <= ts;
		roll_0  <= ang[0];
		pitch_0 <= ang[1];
		roll_1  <= ang[2];
		pitch_1 <= ang[3];
		roll_2  <= ang[4];
		pitch_2 <= ang[5];
		roll_3  <= ang[6];
		pitch_3 <= ang[7];
		roll_4  <= ang[8];
		pitch_4 <= ang[9];
		invalid_mask <= mask;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		queue_frame(ts, ang, mask);
	endtask

	task automatic test_directed_extremes();
		int small_vals[10] = '{1, -1, 255, -255, 256, -256, 3, -3, 128, -128};
		logic [9:0][23:0] ang;
		send_sample(32'h0000_0000, angles_of(0, 0), 10'h000);
		send_sample(32'hFFFF_FFFF, angles_of(24'h7FFFFF, 24'h7FFFFF), 10'h000);
		send_sample(32'h8000_0000, angles_of(-8388608, -8388608), 10'h000);
		send_sample(32'h0000_0001, angles_of(ROLL_LIMIT_Q8, PITCH_LIMIT_Q8), 10'h000);
		send_sample(32'h7FFF_FFFF, angles_of(-int'(ROLL_LIMIT_Q8), -int'(PITCH_LIMIT_Q8)),
			10'h000);
		send_sample(32'hA5A5_5A5A, angles_of(ROLL_LIMIT_Q8 + 1, PITCH_LIMIT_Q8 + 1), 10'h000);
		send_sample(32'h5A5A_A5A5, angles_of(-int'(ROLL_LIMIT_Q8) - 1,
			-int'(PITCH_LIMIT_Q8) - 1), 10'h000);
		// pitch sees the roll limit and must clamp, roll stays in range
		send_sample(32'h1234_5678, angles_of(PITCH_LIMIT_Q8, ROLL_LIMIT_Q8), 10'h000);
		// truncation toward zero on small magnitudes of both signs
		for (int k = 0; k < 10; k++)
			ang[k] = 24'(small_vals[k]);
		send_sample(32'hDEAD_BEEF, ang, 10'h000);
	endtask

	task automatic test_invalid_masks();
		send_sample(32'hCAFE_F00D, angles_of(24'h7FFFFF, -8388608), 10'h3FF);
		send_sample($urandom, random_angles(), 10'h155);
		send_sample($urandom, random_angles(), 10'h2AA);
		for (int b = 0; b < 10; b++)
			send_sample($urandom, random_angles(), 10'(1 << b));
	endtask

	task automatic test_random_frames(int count);
		logic [9:0] mask;
		for (int n = 0; n < count; n++) begin
			mask = ($urandom_range(0, 1) == 0) ? 10'h000 : 10'($urandom);
			send_sample($urandom, random_angles(), mask);
		end
	endtask

	task automatic test_back_to_back(int count);
		idle_en = 1'b0;
		test_random_frames(count);
	endtask

	// Output side: hold ready for random runs; while idle_en is set, drop it in bursts of random length.
	always @(posedge clk) begin
		if (sink_hold != 0)
			sink_hold <= sink_hold - 1;
		else if (!out_ready) begin
			out_ready <= 1'b1;
			sink_hold <= $urandom_range(0, 40);
		end else if (idle_en && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			sink_hold <= $urandom_range(0, 14);
		end
	end

	always @(posedge clk) begin
		frame_beat_t exp_beat;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_bytes.size() == 0) begin
				$error("frame_byte with nothing pending: actual %02h", frame_byte);
				mismatches++;
			end else begin
				exp_beat = pending_bytes.pop_front();
				if (frame_byte !== exp_beat.data) begin
					$error("frame_byte expected %02h actual %02h", exp_beat.data, frame_byte);
					mismatches++;
				end
				if (last_byte !== exp_beat.last) begin
					$error("last_byte expected %0b actual %0b", exp_beat.last, last_byte);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_invalid_masks();
		test_random_frames(300);
		test_back_to_back(40);
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
